[rtl/tahp_pkg.sv]
`timescale 1ns / 1ps
package tahp_pkg;

	localparam logic [1:0] ACT_BEGIN = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_LOADING = 2'd1;
	localparam logic [1:0] PH_LOADED  = 2'd2;
	localparam logic [1:0] PH_FAILED  = 2'd3;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_SHORT    = 3'd1;
	localparam logic [2:0] ERR_RANGE    = 3'd2;
	localparam logic [2:0] ERR_HEADER   = 3'd3;
	localparam logic [2:0] ERR_ARRAYS   = 3'd4;
	localparam logic [2:0] ERR_DIM      = 3'd5;
	localparam logic [2:0] ERR_PAYLOAD  = 3'd6;

	localparam int unsigned HDR_BYTES = 16;
	localparam int unsigned VER_POS   = 3;
	localparam int unsigned FIRST_POS = 11;
	localparam int unsigned LAST_POS  = 15;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic cap;
		logic rd;
		logic mul;
		logic exec;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_stall;
	} dp_sts_t;

endpackage

[rtl/tahp_if.sv]
`timescale 1ns / 1ps
interface tahp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  data_byte;
	logic [12:0] tile_sel;

	modport source (output valid, action, data_byte, tile_sel, input ready);
	modport sink (input valid, action, data_byte, tile_sel, output ready);
endinterface

interface tahp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  load_phase;
	logic [2:0]  error_code;
	logic        found;
	logic [12:0] tile_width;
	logic [12:0] tile_height;
	logic [31:0] pixel_start;
	logic [31:0] lut_start;
	logic [8:0]  lut_size;

	modport source (output valid, load_phase, error_code, found, tile_width, tile_height,
		pixel_start, lut_start, lut_size, input ready);
	modport sink (input valid, load_phase, error_code, found, tile_width, tile_height,
		pixel_start, lut_start, lut_size, output ready);
endinterface

[rtl/tile_archive_header_parser.sv]
`timescale 1ns / 1ps
// channel   dir  handshake     payload
// inp       in   valid/ready   action, data_byte, tile_sel
// res       out  valid/ready   load_phase, error_code, found, tile_width, tile_height,
//                              pixel_start, lut_start, lut_size
// apb       in   psel/penable  archive_length at address 0
// Every item passes through four steps: accept, table read, multiply, update; the next is accepted after the update.
// The table read uses one read port on each of the three tile stores.
// A result held in the output register does not block acceptance; the update
// step waits only while a previous result is still untaken.
// arst_n clears all load state; the tile stores keep no reset.
module tile_archive_header_parser #(
	parameter int unsigned MAX_TILES     = 8192,
	parameter int unsigned MAX_DIMENSION = 4096,
	parameter int unsigned LOOKUP_STRIDE = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	tahp_in_if.sink      inp,
	tahp_out_if.source   res,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	tahp_pkg::ctl_cmd_t cmd;
	tahp_pkg::dp_sts_t  sts;
	logic [31:0]        alen_q;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : alen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alen_q <= '0;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			alen_q <= pwdata;
		end
	end

	tahp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (inp.valid),
		.in_ready (inp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tahp_dpath #(
		.MAX_TILES     (MAX_TILES),
		.MAX_DIMENSION (MAX_DIMENSION),
		.LOOKUP_STRIDE (LOOKUP_STRIDE)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.archive_length (alen_q),
		.action         (inp.action),
		.data_byte      (inp.data_byte),
		.tile_sel       (inp.tile_sel),
		.out_valid      (res.valid),
		.out_ready      (res.ready),
		.load_phase     (res.load_phase),
		.error_code     (res.error_code),
		.found          (res.found),
		.tile_width     (res.tile_width),
		.tile_height    (res.tile_height),
		.pixel_start    (res.pixel_start),
		.lut_start      (res.lut_start),
		.lut_size       (res.lut_size)
	);

endmodule

[rtl/tahp_ctrl.sv]
`timescale 1ns / 1ps
module tahp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tahp_pkg::dp_sts_t   sts,
	output tahp_pkg::ctl_cmd_t  cmd
);

	tahp_pkg::state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tahp_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			tahp_pkg::ST_IDLE: if (in_valid) state_n = tahp_pkg::ST_READ;
			tahp_pkg::ST_READ: state_n = tahp_pkg::ST_MUL;
			tahp_pkg::ST_MUL:  state_n = tahp_pkg::ST_EXEC;
			tahp_pkg::ST_EXEC: if (!sts.out_stall) state_n = tahp_pkg::ST_IDLE;
			default:           state_n = tahp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == tahp_pkg::ST_IDLE);
		cmd.cap  = in_ready && in_valid;
		cmd.rd   = (state_q == tahp_pkg::ST_READ);
		cmd.mul  = (state_q == tahp_pkg::ST_MUL);
		cmd.exec = (state_q == tahp_pkg::ST_EXEC) && !sts.out_stall;
	end

endmodule

[rtl/tahp_dpath.sv]
`timescale 1ns / 1ps
module tahp_dpath #(
	parameter int unsigned MAX_TILES     = 8192,
	parameter int unsigned MAX_DIMENSION = 4096,
	parameter int unsigned LOOKUP_STRIDE = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tahp_pkg::ctl_cmd_t  cmd,
	output tahp_pkg::dp_sts_t   sts,
	input  logic [31:0]         archive_length,
	input  logic [1:0]          action,
	input  logic [7:0]          data_byte,
	input  logic [12:0]         tile_sel,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          load_phase,
	output logic [2:0]          error_code,
	output logic                found,
	output logic [12:0]         tile_width,
	output logic [12:0]         tile_height,
	output logic [31:0]         pixel_start,
	output logic [31:0]         lut_start,
	output logic [8:0]          lut_size
);

	localparam int unsigned AW   = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
	localparam int unsigned TTW  = $clog2(MAX_TILES + 1);
	localparam int unsigned PW   = $clog2(tahp_pkg::HDR_BYTES + 4 * MAX_TILES + 1);
	localparam int unsigned DW   = $clog2(MAX_DIMENSION + 1);
	localparam int unsigned PTW  = 2 * DW + TTW;
	localparam int unsigned SW   = $clog2(LOOKUP_STRIDE + 1);
	localparam int unsigned OFFW = 13 + SW;

	logic [15:0]    wmem [MAX_TILES];
	logic [15:0]    hmem [MAX_TILES];
	logic [PTW-1:0] pmem [MAX_TILES];

	logic [1:0]     act_q;
	logic [7:0]     byte_q;
	logic [12:0]    ti_q;
	logic [PW-1:0]  pos_q;
	logic [31:0]    hdr_q, ver_q, first_q, lr_q;
	logic [TTW-1:0] tt_q;
	logic [7:0]     low_q;
	logic [PTW-1:0] pt_q;
	logic [1:0]     phase_q;
	logic [2:0]     fault_q;
	logic [15:0]    w_rd_q, h_rd_q;
	logic [PTW-1:0] p_rd_q;
	logic [31:0]    prod_q;
	logic [OFFW-1:0] off_q;

	logic [PW-1:0]  q, span, q2;
	logic           is_hdr, in_w, in_h;
	logic [AW-1:0]  idx, rd_addr;
	logic [15:0]    hval;
	logic [31:0]    hdr_n;
	logic [32:0]    count;
	logic [PTW-1:0] pt_n;
	logic [63:0]    avail;
	logic [31:0]    pix_base, left;
	logic           q_hit, lk_hit;

	logic [1:0]     phase_n;
	logic [2:0]     fault_n;
	logic           w_we, h_we, p_we, tt_we, lr_we, pt_we, low_we;

	assign q       = pos_q - PW'(tahp_pkg::HDR_BYTES);
	assign span    = PW'({tt_q, 1'b0});
	assign q2      = q - span;
	assign is_hdr  = pos_q < PW'(tahp_pkg::HDR_BYTES);
	assign in_w    = q < span;
	assign in_h    = !in_w && (q2 < span);
	assign idx     = in_w ? AW'(q >> 1) : AW'(q2 >> 1);
	assign rd_addr = (act_q == tahp_pkg::ACT_QUERY) ? AW'(ti_q) : idx;
	assign hval    = {byte_q, low_q};
	assign hdr_n   = {byte_q, hdr_q[31:8]};
	assign count   = {1'b0, hdr_n} - {1'b0, first_q} + 33'd1;
	assign pt_n    = pt_q + PTW'(prod_q);
	assign avail   = {32'd0, archive_length} - 64'(tahp_pkg::HDR_BYTES) - (64'(tt_q) << 3);
	assign pix_base = 32'(tahp_pkg::HDR_BYTES) + (32'(tt_q) << 3);
	assign q_hit   = (phase_q == tahp_pkg::PH_LOADED) && (32'(ti_q) < 32'(tt_q))
		&& (32'(ti_q) < MAX_TILES) && (w_rd_q != 16'd0) && (h_rd_q != 16'd0);
	assign lk_hit  = 64'(off_q) < 64'(lr_q);
	assign left    = lr_q - 32'(off_q);
	assign sts.out_stall = out_valid && !out_ready;

	always_comb begin
		phase_n = phase_q;
		fault_n = fault_q;
		w_we = 1'b0;
		h_we = 1'b0;
		p_we = 1'b0;
		tt_we = 1'b0;
		lr_we = 1'b0;
		pt_we = 1'b0;
		low_we = 1'b0;
		unique case (act_q)
			tahp_pkg::ACT_BEGIN: begin
				phase_n = tahp_pkg::PH_LOADING;
				fault_n = tahp_pkg::ERR_NONE;
				if (archive_length < 32'(tahp_pkg::HDR_BYTES)) begin
					phase_n = tahp_pkg::PH_FAILED;
					fault_n = tahp_pkg::ERR_SHORT;
				end
			end
			tahp_pkg::ACT_BYTE: begin
				if (phase_q == tahp_pkg::PH_LOADING) begin
					if (is_hdr) begin
						if (pos_q == PW'(tahp_pkg::LAST_POS)) begin
							priority if (hdr_n < first_q) begin
								phase_n = tahp_pkg::PH_FAILED;
								fault_n = tahp_pkg::ERR_RANGE;
							end else if (ver_q != 32'd1 || count > 33'(MAX_TILES)) begin
								phase_n = tahp_pkg::PH_FAILED;
								fault_n = tahp_pkg::ERR_HEADER;
							end else if (36'(archive_length) <
								36'(tahp_pkg::HDR_BYTES) + (36'(count) << 3)) begin
								phase_n = tahp_pkg::PH_FAILED;
								fault_n = tahp_pkg::ERR_ARRAYS;
							end else begin
								tt_we = 1'b1;
							end
						end
					end else if (!q[0]) begin
						low_we = 1'b1;
					end else if (in_w) begin
						w_we = 1'b1;
					end else if (in_h) begin
						h_we = 1'b1;
						if (32'(w_rd_q) > MAX_DIMENSION || 32'(hval) > MAX_DIMENSION) begin
							phase_n = tahp_pkg::PH_FAILED;
							fault_n = tahp_pkg::ERR_DIM;
						end else begin
							p_we = 1'b1;
							pt_we = 1'b1;
							if (32'(idx) + 32'd1 == 32'(tt_q)) begin
								if (64'(pt_n) > avail) begin
									phase_n = tahp_pkg::PH_FAILED;
									fault_n = tahp_pkg::ERR_PAYLOAD;
								end else begin
									lr_we = 1'b1;
									phase_n = tahp_pkg::PH_LOADED;
								end
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			act_q  <= action;
			byte_q <= data_byte;
			ti_q   <= tile_sel;
		end
		if (cmd.rd) begin
			w_rd_q <= wmem[rd_addr];
			h_rd_q <= hmem[rd_addr];
			p_rd_q <= pmem[rd_addr];
		end
		if (cmd.mul) begin
			prod_q <= 32'(w_rd_q) * 32'(hval);
			off_q  <= OFFW'(ti_q) * OFFW'(LOOKUP_STRIDE);
		end
		if (cmd.exec) begin
			if (w_we) wmem[idx] <= hval;
			if (h_we) hmem[idx] <= hval;
			if (p_we) pmem[idx] <= pt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hdr_q   <= '0;
			ver_q   <= '0;
			first_q <= '0;
			tt_q    <= '0;
			low_q   <= '0;
			pt_q    <= '0;
			lr_q    <= '0;
			phase_q <= tahp_pkg::PH_IDLE;
			fault_q <= tahp_pkg::ERR_NONE;
		end else if (cmd.exec) begin
			phase_q <= phase_n;
			fault_q <= fault_n;
			if (act_q == tahp_pkg::ACT_BEGIN) begin
				pos_q   <= '0;
				hdr_q   <= '0;
				ver_q   <= '0;
				first_q <= '0;
				tt_q    <= '0;
				low_q   <= '0;
				pt_q    <= '0;
				lr_q    <= '0;
			end else if (act_q == tahp_pkg::ACT_BYTE && phase_q == tahp_pkg::PH_LOADING) begin
				pos_q <= pos_q + PW'(1);
				if (is_hdr) begin
					hdr_q <= hdr_n;
					if (pos_q == PW'(tahp_pkg::VER_POS)) ver_q <= hdr_n;
					if (pos_q == PW'(tahp_pkg::FIRST_POS)) first_q <= hdr_n;
				end
				if (tt_we) tt_q <= TTW'(count);
				if (low_we) low_q <= byte_q;
				if (pt_we) pt_q <= pt_n;
				if (lr_we) lr_q <= 32'(avail - 64'(pt_n));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.exec) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			load_phase  <= phase_n;
			error_code  <= fault_n;
			found       <= 1'b0;
			tile_width  <= '0;
			tile_height <= '0;
			pixel_start <= '0;
			lut_start   <= '0;
			lut_size    <= '0;
			if (act_q == tahp_pkg::ACT_QUERY && q_hit) begin
				found       <= 1'b1;
				tile_width  <= 13'(w_rd_q);
				tile_height <= 13'(h_rd_q);
				pixel_start <= pix_base + 32'(p_rd_q);
				if (lk_hit) begin
					lut_start <= pix_base + 32'(pt_q) + 32'(off_q);
					lut_size  <= (64'(left) < 64'(LOOKUP_STRIDE)) ? 9'(left)
						: 9'(LOOKUP_STRIDE);
				end
			end
		end
	end

endmodule

[rtl/tahp_checker.sv]
`timescale 1ns / 1ps
module tahp_props (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  load_phase,
	input logic [2:0]  error_code,
	input logic        found,
	input logic [12:0] tile_width,
	input logic [31:0] pixel_start,
	input logic [31:0] lut_start,
	input logic [8:0]  lut_size
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(load_phase) && $stable(pixel_start))
		else $error("result dropped while stalled");

	a_found_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> load_phase == tahp_pkg::PH_LOADED)
		else $error("tile found outside loaded phase");

	a_err_failed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != tahp_pkg::ERR_NONE |-> load_phase == tahp_pkg::PH_FAILED)
		else $error("error code without failed phase");

	a_lookup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lut_size == 9'd0 |-> lut_start == 32'd0)
		else $error("lookup start without lookup size");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> tile_width == 13'd0 && pixel_start == 32'd0)
		else $error("tile fields set on a miss");

endmodule

bind tile_archive_header_parser tahp_props u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.load_phase   (res.load_phase),
	.error_code   (res.error_code),
	.found        (res.found),
	.tile_width   (res.tile_width),
	.pixel_start  (res.pixel_start),
	.lut_start    (res.lut_start),
	.lut_size     (res.lut_size)
);
